// File: hw/rtl/ihex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared constants and character helpers for the Intel HEX record encoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int RECORD_BYTES_DEF = 16;
    localparam int ADDR_W           = 16;
    localparam int CHAR_W           = 7;
    localparam int EOF_LEN          = 12;

    localparam logic [CHAR_W-1:0] CH_COLON   = 7'h3A;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 7'h0A;
    localparam logic [7:0]        REC_TYPE_DATA = 8'h00;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
        end else begin
            c = 7'h37 + {3'b000, nib};
        end
        return c;
    endfunction

    // ":00000001FF" followed by newline
    function automatic logic [CHAR_W-1:0] eof_char(input logic [3:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            4'd0:    c = CH_COLON;
            4'd7:    c = 7'h30;
            4'd8:    c = 7'h31;
            4'd9:    c = 7'h46;
            4'd10:   c = 7'h46;
            4'd11:   c = CH_NEWLINE;
            default: c = 7'h30;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/ihex_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihex_buf
// Record byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ihex_buf import ihex_pkg::*; #(
    parameter int DEPTH = RECORD_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/intel_hex_record_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_record_encoder
// Packs image bytes into Intel HEX data records and streams them as ASCII.
//
// Input channel (s_*): one image byte per transaction, s_tlast marks the
// final byte of an image. Output channel (m_*): one ASCII character per
// transaction; m_tlast is set on the final character caused by an input byte.
// A byte that neither fills the record nor carries tlast is buffered and
// produces no output; s_tready stays high for the next cycle.
// A flushed record of n bytes emits 12 + 2n characters, one per cycle while
// the receiver accepts them, from a single character sequencer sharing one
// 8-bit checksum adder; an image end adds 12 more for the EOF record.
// s_tready is low from the flushing byte until the last character has been
// loaded into the output register, so the input is held off while a record
// is streamed and new bytes are taken only between records.
// A stalled receiver freezes the sequencer; the output register holds.
// Reset clears fill count, address and sequencer; buffer contents are not
// cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder import ihex_pkg::*; #(
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] ascii_char, [7] zero
    output logic       m_tlast    // last_of_run
);

    localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CNT_W = $clog2(RECORD_BYTES + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_COLON  = 7'b0000010,
        ST_HEADER = 7'b0000100,
        ST_DATA   = 7'b0001000,
        ST_CKSUM  = 7'b0010000,
        ST_NL     = 7'b0100000,
        ST_EOF    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                lastf_reg, lastf_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [1:0]          hdr_reg, hdr_next;
    logic                nib_reg, nib_next;
    logic [3:0]          eof_reg, eof_next;
    logic [7:0]          sum_reg, sum_next;
    logic                ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]   ochar_reg, ochar_next;
    logic                olast_reg, olast_next;

    logic                out_free;
    logic                wr_en;
    logic [7:0]          rd_data;
    logic [7:0]          hdr_byte;
    logic [7:0]          cur_byte;
    logic [3:0]          cur_nib;
    logic [CNT_W-1:0]    fill_inc;
    logic [CNT_W-1:0]    fill_m1;

    ihex_buf #(
        .DEPTH (RECORD_BYTES),
        .AW    (IDX_W)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign wr_en    = s_tvalid && s_tready;
    assign fill_inc = fill_reg + CNT_W'(1);
    assign fill_m1  = fill_reg - CNT_W'(1);

    always_comb begin
        case (hdr_reg)
            2'd0:    hdr_byte = 8'(fill_reg);
            2'd1:    hdr_byte = addr_reg[15:8];
            2'd2:    hdr_byte = addr_reg[7:0];
            default: hdr_byte = REC_TYPE_DATA;
        endcase
    end

    always_comb begin
        case (state_reg)
            ST_DATA:  cur_byte = rd_data;
            ST_CKSUM: cur_byte = 8'h00 - sum_reg;
            default:  cur_byte = hdr_byte;
        endcase
    end

    assign cur_nib = nib_reg ? cur_byte[3:0] : cur_byte[7:4];

    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        addr_next   = addr_reg;
        lastf_next  = lastf_reg;
        idx_next    = idx_reg;
        hdr_next    = hdr_reg;
        nib_next    = nib_reg;
        eof_next    = eof_reg;
        sum_next    = sum_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fill_next  = fill_inc;
                    lastf_next = s_tlast;
                    if (s_tlast || fill_inc == CNT_W'(RECORD_BYTES)) begin
                        state_next = ST_COLON;
                    end
                end
            end
            ST_COLON: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = CH_COLON;
                    olast_next  = 1'b0;
                    sum_next    = 8'h00;
                    hdr_next    = 2'd0;
                    nib_next    = 1'b0;
                    idx_next    = '0;
                    state_next  = ST_HEADER;
                end
            end
            ST_HEADER, ST_DATA, ST_CKSUM: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = hex_char(cur_nib);
                    olast_next  = 1'b0;
                    nib_next    = !nib_reg;
                    if (nib_reg) begin
                        sum_next = sum_reg + cur_byte;
                        if (state_reg == ST_HEADER) begin
                            hdr_next = hdr_reg + 2'd1;
                            if (hdr_reg == 2'd3) begin
                                state_next = ST_DATA;
                            end
                        end else if (state_reg == ST_DATA) begin
                            if (CNT_W'(idx_reg) == fill_m1) begin
                                state_next = ST_CKSUM;
                            end else begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end else begin
                            state_next = ST_NL;
                        end
                    end
                end
            end
            ST_NL: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = CH_NEWLINE;
                    olast_next  = !lastf_reg;
                    addr_next   = addr_reg + ADDR_W'(fill_reg);
                    fill_next   = '0;
                    eof_next    = 4'd0;
                    state_next  = lastf_reg ? ST_EOF : ST_IDLE;
                end
            end
            ST_EOF: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    ochar_next  = eof_char(eof_reg);
                    olast_next  = (eof_reg == 4'(EOF_LEN - 1));
                    eof_next    = eof_reg + 4'd1;
                    if (eof_reg == 4'(EOF_LEN - 1)) begin
                        addr_next  = '0;
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            addr_reg   <= addr_next;
            ovalid_reg <= ovalid_next;
        end
        lastf_reg <= lastf_next;
        idx_reg   <= idx_next;
        hdr_reg   <= hdr_next;
        nib_reg   <= nib_next;
        eof_reg   <= eof_next;
        sum_reg   <= sum_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {1'b0, ochar_reg};
    assign m_tlast  = olast_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(RECORD_BYTES))
        else $error("fill count above record size");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DATA |-> CNT_W'(idx_reg) < fill_reg)
        else $error("data index beyond filled bytes");

    a_last_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[6:0] == CH_NEWLINE)
        else $error("run ends on a character other than newline");

    a_last_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready && state_reg == ST_COLON)
        else $error("last byte did not start a flush");

endmodule
